// File: src/fcce_pkg.sv
// Shared types and constants for the cluster chain engine.
package fcce_pkg;

    localparam int LINK_W = 28;
    localparam int CLUS_W = 12;
    localparam int CEXT_W = 13;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [LINK_W-1:0] END_MARK = 28'hFFFFFFF;
    localparam logic [LINK_W-1:0] END_LOW  = 28'hFFFFFF8;

    localparam logic [CLUS_W-1:0] CFG_RESET  = 12'd4094;
    localparam logic [CLUS_W-1:0] HINT_RESET = 12'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CLUS_W-1:0] cluster;
        logic [LINK_W-1:0] link_value;
    } fcce_req_t;

    typedef struct packed {
        logic [LINK_W-1:0] result_value;
        logic [CLUS_W-1:0] freed_count;
        logic [1:0]        status;
    } fcce_rsp_t;

endpackage

// File: src/fcce_link_ram.sv
// Link table memory: one write port, one registered read port.
module fcce_link_ram #(
    parameter int DEPTH = 4097,
    parameter int AW    = 13
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [fcce_pkg::LINK_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [fcce_pkg::LINK_W-1:0] rdata
);
    import fcce_pkg::*;

    logic [LINK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: src/fcce_mod_unit.sv
// Serial remainder unit: one restoring step per cycle over 12 dividend bits.
module fcce_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [fcce_pkg::CLUS_W-1:0] dividend,
    input  logic [fcce_pkg::CLUS_W-1:0] divisor,
    output logic                        done,
    output logic [fcce_pkg::CLUS_W-1:0] remainder
);
    import fcce_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(CLUS_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [3:0]        step_reg, step_next;
    logic [CLUS_W-1:0] dvd_reg, dvd_next;
    logic [CLUS_W-1:0] dsr_reg, dsr_next;
    logic [CLUS_W-1:0] rem_reg, rem_next;
    logic [CLUS_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[CLUS_W-1]};
        if (go)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CLUS_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[CLUS_W-1:0];
            end
            dvd_next  = {dvd_reg[CLUS_W-2:0], 1'b0};
            step_next = step_reg + 4'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: src/fat_cluster_chain_engine.sv
// Top level: cluster link table with next-fit allocation and chain free.
//
// One item at a time. A write, any out-of-range request or an allocate with
// no clusters answers in the cycle after acceptance with busy low; any other
// item holds busy high until its response strobe. Allocate probes each entry
// through S_SC_A and S_SC_D, after a serial remainder of the hint when the
// hint is two or more; free walks each link through S_FR_A and a data step.
// Both walks are bounded by the registered-read link RAM. After reset the
// table is cleared one entry per cycle (min(TABLE_DEPTH, 4097) entries, 4096
// at the default depth) with busy high; configuration writes are taken
// meanwhile. The response is a one-cycle strobe and cannot be held off.
module fat_cluster_chain_engine #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fcce_pkg::fcce_req_t         request,
    output logic                        done,
    output fcce_pkg::fcce_rsp_t         response,
    input  logic                        cfg_we,
    input  logic [fcce_pkg::CLUS_W-1:0] cfg_wdata
);
    import fcce_pkg::*;

    localparam int MEM_DEPTH = (TABLE_DEPTH < 4097) ? TABLE_DEPTH : 4097;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [CLUS_W-1:0] LIM = CLUS_W'(MEM_DEPTH - 2);
    localparam logic [AW-1:0]     CLR_LAST = AW'(MEM_DEPTH - 1);
    localparam logic [AW-1:0]     ALLOC_BASE = AW'(2);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD_A  = 3'd2;
    localparam logic [2:0] S_RD_D  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SC_A  = 3'd5;
    localparam logic [2:0] S_SC_D  = 3'd6;
    localparam logic [2:0] S_FR_A  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic              fr_d_reg, fr_d_next;
    logic [CLUS_W-1:0] cfg_reg;
    logic [CLUS_W-1:0] hint_reg, hint_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CLUS_W-1:0] count_reg, count_next;
    logic [CLUS_W-1:0] scan_reg, scan_next;
    logic [CLUS_W-1:0] freed_reg, freed_next;
    logic              done_reg, done_next;
    fcce_rsp_t         rsp_reg, rsp_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [LINK_W-1:0] mem_rdata;

    logic              div_go;
    logic              div_done;
    logic [CLUS_W-1:0] div_rem;

    logic [CLUS_W-1:0] eff_cnt;
    logic              clus_ok;
    logic              link_ok;
    logic [CEXT_W-1:0] addr_ext;
    logic [CEXT_W-1:0] last_clus;
    logic [CLUS_W-1:0] freed_inc;
    logic [CLUS_W-1:0] scan_inc;

    fcce_link_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    fcce_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (hint_reg - 12'd2),
        .divisor   (eff_cnt),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign eff_cnt   = (cfg_reg < LIM) ? cfg_reg : LIM;
    assign clus_ok   = (request.cluster >= 12'd2)
                       && ((request.cluster - 12'd2) < eff_cnt);
    assign link_ok   = (mem_rdata >= 28'd2)
                       && ((mem_rdata - 28'd2) < LINK_W'(count_reg));
    assign addr_ext  = CEXT_W'(addr_reg);
    assign last_clus = CEXT_W'(count_reg) + CEXT_W'(1);
    assign freed_inc = freed_reg + 12'd1;
    assign scan_inc  = scan_reg + 12'd1;

    always_comb
    begin
        state_next = state_reg;
        fr_d_next  = 1'b0;
        hint_next  = hint_reg;
        addr_next  = addr_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        freed_next = freed_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = '0;
        div_go     = 1'b0;

        if (fr_d_reg)
        begin
            // chain free: examine the link just read
            if (mem_rdata == '0)
            begin
                done_next             = 1'b1;
                rsp_next.freed_count  = freed_reg;
                state_next            = S_IDLE;
            end
            else
            begin
                mem_we               = 1'b1;
                freed_next           = freed_inc;
                rsp_next.freed_count = freed_inc;
                if (mem_rdata >= END_LOW)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!link_ok)
                begin
                    done_next       = 1'b1;
                    rsp_next.status = ST_RANGE;
                    state_next      = S_IDLE;
                end
                else if (freed_inc == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next  = AW'(mem_rdata);
                    state_next = S_FR_A;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = clr_reg;
                    clr_next  = clr_reg + AW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        count_next = eff_cnt;
                        scan_next  = '0;
                        freed_next = '0;
                        addr_next  = AW'(request.cluster);
                        rsp_next   = '{result_value: '0, freed_count: '0, status: ST_OK};
                        unique case (request.operation)
                            OP_READ:
                            begin
                                if (clus_ok)
                                begin
                                    state_next = S_RD_A;
                                end
                                else
                                begin
                                    done_next       = 1'b1;
                                    rsp_next.status = ST_RANGE;
                                end
                            end
                            OP_WRITE:
                            begin
                                done_next = 1'b1;
                                if (clus_ok)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = AW'(request.cluster);
                                    mem_wdata = request.link_value;
                                end
                                else
                                begin
                                    rsp_next.status = ST_RANGE;
                                end
                            end
                            OP_ALLOC:
                            begin
                                addr_next = ALLOC_BASE;
                                if (eff_cnt == '0)
                                begin
                                    done_next       = 1'b1;
                                    rsp_next.status = ST_FULL;
                                end
                                else if (hint_reg >= 12'd2)
                                begin
                                    div_go     = 1'b1;
                                    state_next = S_DIV;
                                end
                                else
                                begin
                                    state_next = S_SC_A;
                                end
                            end
                            OP_FREE:
                            begin
                                if (clus_ok)
                                begin
                                    state_next = S_FR_A;
                                end
                                else
                                begin
                                    done_next       = 1'b1;
                                    rsp_next.status = ST_RANGE;
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD_A:
                begin
                    state_next = S_RD_D;
                end
                S_RD_D:
                begin
                    done_next             = 1'b1;
                    rsp_next.result_value = mem_rdata;
                    state_next            = S_IDLE;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        addr_next  = AW'(div_rem) + ALLOC_BASE;
                        state_next = S_SC_A;
                    end
                end
                S_SC_A:
                begin
                    state_next = S_SC_D;
                end
                S_SC_D:
                begin
                    if (mem_rdata == '0)
                    begin
                        mem_we                = 1'b1;
                        mem_wdata             = END_MARK;
                        hint_next             = addr_ext[CLUS_W-1:0] + 12'd1;
                        rsp_next.result_value = LINK_W'(addr_ext);
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                    else if (scan_inc == count_reg)
                    begin
                        rsp_next.status = ST_FULL;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_inc;
                        addr_next  = (addr_ext == last_clus) ? ALLOC_BASE : addr_reg + AW'(1);
                        state_next = S_SC_A;
                    end
                end
                S_FR_A:
                begin
                    fr_d_next = 1'b1;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            fr_d_reg  <= 1'b0;
            clr_reg   <= '0;
            hint_reg  <= HINT_RESET;
            cfg_reg   <= CFG_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fr_d_reg  <= fr_d_next;
            clr_reg   <= clr_next;
            hint_reg  <= hint_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        count_reg <= count_next;
        scan_reg  <= scan_next;
        freed_reg <= freed_next;
        rsp_reg   <= rsp_next;
    end

    assign busy     = (state_reg != S_IDLE) || fr_d_reg;
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

// File: src/fcce_checker.sv
// Port-level checks for the cluster chain engine, bound to the top level.
module fcce_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input fcce_pkg::fcce_rsp_t response
);
    import fcce_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response strobe while busy");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor answered");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("response without an item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((response.status == ST_OK) || (response.status == ST_FULL)
                  || (response.status == ST_RANGE)))
        else $error("undefined status code");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status == ST_FULL))
        |-> ((response.result_value == '0) && (response.freed_count == '0)))
        else $error("full response carries data");

endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);
